// File: src/lock_owner_self_deadlock_monitor_macros.svh
// Assertion macros for the lock owner self-deadlock monitor.
// Expects aclk and aresetn in scope of the module that includes it.
`ifndef LOCK_OWNER_SELF_DEADLOCK_MONITOR_MACROS_SVH
`define LOCK_OWNER_SELF_DEADLOCK_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LODM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LODM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/lodm_pkg.sv
// Shared types and constants for the lock owner self-deadlock monitor.
// No dependencies; used by lodm_lookup and the top level.
package lodm_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 64;
    localparam int TID_W   = 22;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [TID_W-1:0]  tid_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_OTHER   = 2'd0,
        OP_START   = 2'd1,
        OP_ACQUIRE = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK            = 2'd0,
        ST_SELF_DEADLOCK = 2'd1,
        ST_TABLE_FULL    = 2'd2,
        ST_HALTED        = 2'd3
    } status_t;

    // Result of one parallel search of the owner table
    typedef struct packed {
        logic hit;         // a valid entry holds the lock address
        logic self_hit;    // ... and its owner is the requesting thread
        idx_t hit_idx;
        logic free_avail;  // at least one slot is free
        idx_t free_idx;    // lowest free slot
    } lookup_t;

endpackage

// File: src/lock_owner_self_deadlock_monitor.sv
// Lock owner self-deadlock monitor: owner table, tracking and halt control.
// Depends on lodm_pkg, lodm_lookup and lock_owner_self_deadlock_monitor_macros.svh.
//
// The monitor takes one lock event per item and returns exactly one result
// per item. Throughput is one item per clock while the result channel does
// not stall: each item is captured in an input register, searched against
// all owner-table entries in parallel (one 64-bit address compare and one
// 22-bit owner compare per entry) and its result is registered in the same
// cycle as the table update, so the next item always sees the updated table.
// The result is offered on m_valid from the result register. While a result
// waits for m_ready, one more item can still be taken into the input register.
// Nothing happens before a start item; after a self-deadlock the block is
// halted until reset and every item is answered with the halted status.
// The table has TABLE_ENTRIES slots, each with a reset-cleared valid bit;
// new locks go into the lowest free slot, and entries_used counts valid slots.
module lock_owner_self_deadlock_monitor (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lodm_pkg::OP_W-1:0]     s_opcode,
    input  logic [lodm_pkg::ADDR_W-1:0]   s_lock_address,
    input  logic [lodm_pkg::TID_W-1:0]    s_thread_id,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lodm_pkg::STAT_W-1:0]   m_status,
    output logic                          m_tracking_active,
    output logic [lodm_pkg::COUNT_W-1:0]  m_entries_used
);
    import lodm_pkg::*;

    `include "lock_owner_self_deadlock_monitor_macros.svh"

    // ---- input register ----
    logic                  in_valid_reg;
    logic [OP_W-1:0]       opcode_reg;
    addr_t                 addr_reg;
    tid_t                  tid_reg;

    // ---- result register ----
    logic                  out_valid_reg;
    status_t               status_reg;
    logic                  trk_out_reg;
    logic [COUNT_W-1:0]    cnt_out_reg;

    // ---- monitor state ----
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    addr_t                    entry_addr [TABLE_ENTRIES];
    tid_t                     entry_owner [TABLE_ENTRIES];
    logic                     tracking_reg, tracking_next;
    logic                     halted_reg, halted_next;
    logic [COUNT_W-1:0]       count_reg, count_next;

    // table write port
    logic    wr_en;
    logic    wr_addr_en;   // new entry: address written too
    idx_t    wr_idx;
    status_t status_next;

    lookup_t lk;
    logic    advance;

    // item in the input register moves on when the result slot is free or being taken
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    lodm_lookup u_lookup (
        .entry_valid (valid_reg),
        .entry_addr  (entry_addr),
        .entry_owner (entry_owner),
        .key_addr    (addr_reg),
        .key_tid     (tid_reg),
        .result      (lk)
    );

    // ---- per-item decision ----
    always_comb begin
        status_next   = ST_OK;
        tracking_next = tracking_reg;
        halted_next   = halted_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        wr_en         = 1'b0;
        wr_addr_en    = 1'b0;
        wr_idx        = lk.hit_idx;

        if (halted_reg) begin
            status_next = ST_HALTED;
        end else begin
            unique case (op_t'(opcode_reg))
                OP_START: begin
                    tracking_next = 1'b1;
                end
                OP_ACQUIRE: begin
                    if (tracking_reg) begin
                        if (lk.hit) begin
                            if (lk.self_hit) begin
                                // owner re-acquires its own lock
                                status_next = ST_SELF_DEADLOCK;
                                halted_next = 1'b1;
                            end else begin
                                wr_en = 1'b1;   // overwrite owner only
                            end
                        end else if (lk.free_avail) begin
                            wr_en              = 1'b1;
                            wr_addr_en         = 1'b1;
                            wr_idx             = lk.free_idx;
                            valid_next[wr_idx] = 1'b1;
                            count_next         = count_reg + 1'b1;
                        end else begin
                            status_next = ST_TABLE_FULL;
                        end
                    end
                end
                OP_RELEASE: begin
                    if (tracking_reg && lk.hit) begin
                        valid_next[lk.hit_idx] = 1'b0;
                        count_next             = count_reg - 1'b1;
                    end
                end
                default: begin
                    // other events: no action
                end
            endcase
        end
    end

    // ---- control registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            tracking_reg  <= 1'b0;
            halted_reg    <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                valid_reg     <= valid_next;
                tracking_reg  <= tracking_next;
                halted_reg    <= halted_next;
                count_reg     <= count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            opcode_reg <= s_opcode;
            addr_reg   <= s_lock_address;
            tid_reg    <= s_thread_id;
        end
        if (advance) begin
            status_reg  <= status_next;
            trk_out_reg <= tracking_next;
            cnt_out_reg <= count_next;
        end
    end

    // ---- owner table storage, contents undefined until written ----
    always_ff @(posedge aclk) begin
        if (advance && wr_en) begin
            entry_owner[wr_idx] <= tid_reg;
            if (wr_addr_en) begin
                entry_addr[wr_idx] <= addr_reg;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = status_reg;
    assign m_tracking_active = trk_out_reg;
    assign m_entries_used    = cnt_out_reg;

    // ---- assertions ----
    `LODM_ASSERT_SAME(a_count_tracks_valid, 1'b1, count_reg == COUNT_W'($countones(valid_reg)), "entry count disagrees with valid bits")
    `LODM_ASSERT_NEXT(a_halt_sticky, halted_reg, halted_reg, "halt flag cleared without reset")
    `LODM_ASSERT_SAME(a_halted_status, out_valid_reg && (status_reg == ST_HALTED), halted_reg, "halted status while not halted")
    `LODM_ASSERT_NEXT(a_insert_counts, advance && wr_addr_en, count_reg == $past(count_reg) + 1'b1, "new entry not counted")

endmodule

// File: src/lodm_lookup.sv
// Parallel tag compare and lowest-free-slot search over the owner table.
// Depends on lodm_pkg.
module lodm_lookup (
    input  logic [lodm_pkg::TABLE_ENTRIES-1:0] entry_valid,
    input  lodm_pkg::addr_t                    entry_addr [lodm_pkg::TABLE_ENTRIES],
    input  lodm_pkg::tid_t                     entry_owner [lodm_pkg::TABLE_ENTRIES],
    input  lodm_pkg::addr_t                    key_addr,
    input  lodm_pkg::tid_t                     key_tid,
    output lodm_pkg::lookup_t                  result
);
    import lodm_pkg::*;

    logic [TABLE_ENTRIES-1:0] match;
    logic [TABLE_ENTRIES-1:0] self_match;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match[i]      = entry_valid[i] && (entry_addr[i] == key_addr);
            self_match[i] = match[i] && (entry_owner[i] == key_tid);
        end
    end

    // Priority encoders: scan downwards so the lowest index wins
    always_comb begin
        result            = '0;
        result.hit        = |match;
        result.self_hit   = |self_match;
        result.free_avail = ~&entry_valid;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                result.hit_idx = IDX_W'(i);
            end
            if (!entry_valid[i]) begin
                result.free_idx = IDX_W'(i);
            end
        end
    end

endmodule

// File: tb/sv/lock_table_checker.sv
// Checker for the lock owner self-deadlock monitor: predicts each result item
// from the accepted input items and compares the result channel with it.
// Depends on lodm_pkg for field widths, opcodes and status codes.
module lock_table_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [lodm_pkg::OP_W-1:0]      s_opcode,
    input  lodm_pkg::addr_t                s_lock_address,
    input  lodm_pkg::tid_t                 s_thread_id,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [lodm_pkg::STAT_W-1:0]    m_status,
    input  logic                           m_tracking_active,
    input  logic [lodm_pkg::COUNT_W-1:0]   m_entries_used,
    output int                             mismatches,
    output int                             outstanding
);
    import lodm_pkg::*;

    typedef struct {
        status_t             status;
        logic                tracking;
        logic [COUNT_W-1:0]  used;
    } verdict_t;

    // Shadow owner table and control flags
    logic     tbl_valid [TABLE_ENTRIES];
    addr_t    tbl_addr  [TABLE_ENTRIES];
    tid_t     tbl_owner [TABLE_ENTRIES];
    logic     tracking_on;
    logic     halted;

    verdict_t expected_verdicts [$];
    verdict_t head;

    function automatic verdict_t predict_lock_event(op_t op, addr_t addr, tid_t tid);
        int       hit;
        int       free;
        int       used;
        verdict_t v;
        hit  = -1;
        free = -1;
        used = 0;
        v.status = ST_OK;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_addr[i] == addr && hit < 0)
                hit = i;
            if (!tbl_valid[i] && free < 0)
                free = i;
        end
        if (halted) begin
            v.status = ST_HALTED;
        end else begin
            case (op)
                OP_START: begin
                    tracking_on = 1'b1;
                end
                OP_ACQUIRE: begin
                    if (tracking_on) begin
                        if (hit >= 0) begin
                            if (tbl_owner[hit] == tid) begin
                                v.status = ST_SELF_DEADLOCK;
                                halted   = 1'b1;
                            end else begin
                                tbl_owner[hit] = tid;
                            end
                        end else if (free >= 0) begin
                            tbl_valid[free] = 1'b1;
                            tbl_addr[free]  = addr;
                            tbl_owner[free] = tid;
                        end else begin
                            v.status = ST_TABLE_FULL;
                        end
                    end
                end
                OP_RELEASE: begin
                    if (tracking_on && hit >= 0)
                        tbl_valid[hit] = 1'b0;
                end
                default: ;
            endcase
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i])
                used++;
        v.tracking = tracking_on;
        v.used     = used[COUNT_W-1:0];
        return v;
    endfunction

    // Results are compared before the item of the same edge is predicted:
    // the block cannot answer an item at the edge that accepts it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                tbl_valid[i] = 1'b0;
            tracking_on = 1'b0;
            halted      = 1'b0;
            expected_verdicts.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result item with no input item outstanding");
                    mismatches++;
                end else begin
                    head = expected_verdicts.pop_front();
                    if (m_status !== head.status) begin
                        $error("status: expected %0d, actual %0d", head.status, m_status);
                        mismatches++;
                    end
                    if (m_tracking_active !== head.tracking) begin
                        $error("tracking_active: expected %0d, actual %0d",
                               head.tracking, m_tracking_active);
                        mismatches++;
                    end
                    if (m_entries_used !== head.used) begin
                        $error("entries_used: expected %0d, actual %0d",
                               head.used, m_entries_used);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_verdicts.push_back(
                    predict_lock_event(op_t'(s_opcode), s_lock_address, s_thread_id));
        end
        outstanding = expected_verdicts.size();
    end

endmodule

// File: tb/sv/lock_owner_self_deadlock_monitor_tb.sv
// Testbench top for the lock owner self-deadlock monitor: clock, reset,
// lock event stimulus and the verdict. Depends on lodm_pkg, the block and
// lock_table_checker, which does all prediction and comparison.
module lock_owner_self_deadlock_monitor_tb;
    import lodm_pkg::*;

    localparam int POOL_SIZE      = TABLE_ENTRIES + 8;  // enough locks to overfill the table
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic                aclk              = 1'b0;
    logic                aresetn           = 1'b0;
    logic                s_valid           = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_opcode          = OP_OTHER;
    addr_t               s_lock_address    = '0;
    tid_t                s_thread_id       = '0;
    logic                m_valid;
    logic                m_ready           = 1'b0;
    logic [STAT_W-1:0]   m_status;
    logic                m_tracking_active;
    logic [COUNT_W-1:0]  m_entries_used;

    int                  mismatches;
    int                  outstanding;
    int                  stall_cycles      = 0;

    // Idle chances in percent, changed per phase
    int                  send_idle         = 0;
    int                  recv_idle         = 0;

    // Stimulus-side bookkeeping of a pool of lock addresses: which are held
    // in the block's table and by whom. Every tracked acquire goes through
    // this pool, so held_count follows the table exactly, and the random part
    // can steer clear of a self-deadlock, which would halt the block for good.
    addr_t               pool_addr      [POOL_SIZE];
    logic                lock_held      [POOL_SIZE];
    tid_t                lock_owner_tid [POOL_SIZE];
    int                  held_count     = 0;
    int                  victim;

    always #2 aclk = ~aclk;

    lock_owner_self_deadlock_monitor u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_lock_address    (s_lock_address),
        .s_thread_id       (s_thread_id),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_tracking_active (m_tracking_active),
        .m_entries_used    (m_entries_used)
    );

    lock_table_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_lock_address    (s_lock_address),
        .s_thread_id       (s_thread_id),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_tracking_active (m_tracking_active),
        .m_entries_used    (m_entries_used),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    // Receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: a run of cycles with no item moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("** lock_owner_self_deadlock_monitor: FAILED **");
                $finish;
            end
        end
    end

    function automatic addr_t random_addr();
        return {$urandom, $urandom};
    endfunction

    // Thread ids lean on the extremes now and then
    function automatic tid_t random_tid();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return tid_t'($urandom);
        endcase
    endfunction

    // Offers one item, with random idle cycles ahead of it, and returns at
    // the edge that accepts it. Valid is left high so that back-to-back
    // items need no second assignment in the same step.
    task automatic send_event(input op_t op, input addr_t addr, input tid_t tid);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_lock_address <= addr;
        s_thread_id    <= tid;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Tracked acquire of a pool lock. A thread that already holds the lock
    // is swapped for a neighbour id so that no self-deadlock is raised.
    task automatic acquire_pool(input int k, input tid_t tid);
        if (lock_held[k] && tid == lock_owner_tid[k])
            tid[$urandom_range(TID_W-1)] ^= 1'b1;
        send_event(OP_ACQUIRE, pool_addr[k], tid);
        if (lock_held[k]) begin
            lock_owner_tid[k] = tid;
        end else if (held_count < TABLE_ENTRIES) begin
            lock_held[k]      = 1'b1;
            lock_owner_tid[k] = tid;
            held_count++;
        end
        // else: table full, the acquire is dropped
    endtask

    task automatic release_pool(input int k);
        send_event(OP_RELEASE, pool_addr[k], random_tid());
        if (lock_held[k]) begin
            lock_held[k] = 1'b0;
            held_count--;
        end
        // Fresh addresses now and then; the two extreme addresses stay
        if (k >= 2 && $urandom_range(3) == 0)
            pool_addr[k] = random_addr();
    endtask

    // Mix: mostly acquires and releases of pool locks, so the table keeps
    // filling, overflowing and draining; the rest is releases of unknown
    // locks, other events and repeated starts.
    task automatic run_random(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 42)
                acquire_pool($urandom_range(POOL_SIZE-1), random_tid());
            else if (pick < 72)
                release_pool($urandom_range(POOL_SIZE-1));
            else if (pick < 82)
                send_event(OP_RELEASE, random_addr(), random_tid());
            else if (pick < 92)
                send_event(OP_OTHER, random_addr(), random_tid());
            else
                send_event(OP_START, random_addr(), random_tid());
        end
    endtask

    initial begin
        pool_addr[0] = '0;
        pool_addr[1] = '1;
        for (int k = 0; k < POOL_SIZE; k++) begin
            if (k >= 2)
                pool_addr[k] = random_addr();
            lock_held[k]      = 1'b0;
            lock_owner_tid[k] = '0;
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase one: sender idles a little, receiver a lot
        send_idle = 19;
        recv_idle = 49;

        // Before the start event, acquire and release change nothing
        send_event(OP_ACQUIRE, pool_addr[0], '0);
        send_event(OP_RELEASE, pool_addr[1], '1);
        send_event(OP_OTHER, random_addr(), random_tid());
        // Start, then start again while already tracking
        send_event(OP_START, '0, '0);
        send_event(OP_START, '1, '1);
        // Fill the table; extreme addresses and thread ids go first
        acquire_pool(0, '0);
        acquire_pool(1, '1);
        for (int k = 2; k < TABLE_ENTRIES; k++)
            acquire_pool(k, random_tid());
        // Full table: a new lock is dropped
        acquire_pool(TABLE_ENTRIES, random_tid());
        // Held lock taken by another thread: owner overwritten
        acquire_pool(2, ~lock_owner_tid[2]);
        // Release of an unknown lock, then of a held one
        send_event(OP_RELEASE, random_addr(), random_tid());
        release_pool(3);

        run_random(600);

        // Phase two: the other way round
        send_idle = 49;
        recv_idle = 19;
        run_random(620);

        // Phase three: full rate both ways
        send_idle = 0;
        recv_idle = 0;
        run_random(610);

        // Self-deadlock last, since the block stays halted until reset:
        // the owner of a held lock acquires it again.
        victim = -1;
        for (int k = 0; k < POOL_SIZE; k++)
            if (lock_held[k] && victim < 0)
                victim = k;
        if (victim < 0) begin
            acquire_pool(0, random_tid());
            victim = 0;
        end
        send_event(OP_ACQUIRE, pool_addr[victim], lock_owner_tid[victim]);
        // Halted: every kind of item is ignored
        send_event(OP_OTHER, random_addr(), random_tid());
        send_event(OP_START, random_addr(), random_tid());
        send_event(OP_ACQUIRE, pool_addr[victim], lock_owner_tid[victim] ^ 1'b1);
        send_event(OP_RELEASE, pool_addr[victim], random_tid());

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("** lock_owner_self_deadlock_monitor: PASSED **");
        else
            $display("** lock_owner_self_deadlock_monitor: FAILED **");
        $finish;
    end

endmodule

// File: lock_owner_self_deadlock_monitor.f
+incdir+src
src/lodm_pkg.sv
src/lodm_lookup.sv
src/lock_owner_self_deadlock_monitor.sv
tb/sv/lock_table_checker.sv
tb/sv/lock_owner_self_deadlock_monitor_tb.sv
